/* rtl/core/page_table_frame_allocator_core_defines.svh */
// Assertion macros for the checker file of the frame allocator core
`ifndef PAGE_TABLE_FRAME_ALLOCATOR_CORE_DEFINES_SVH
`define PAGE_TABLE_FRAME_ALLOCATOR_CORE_DEFINES_SVH

// Condition implies consequence in the same cycle
`define PTFA_ASSERT_NOW(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error("ptfa check failed");

// Condition implies consequence in the next cycle
`define PTFA_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("ptfa check failed");

`endif

/* rtl/core/ptfa_pkg.sv */
// Shared constants, codes and control types of the frame allocator core
package ptfa_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int MAX_PAGES     = 64;
    localparam int NUM_FRAMES    = 64;

    localparam int SLOT_W  = 4;
    localparam int PAGE_W  = 6;
    localparam int FRAME_W = 6;
    localparam int CNT_W   = 5;
    localparam int PCNT_W  = 7;
    localparam int IDX_W   = 7;
    localparam int ADDR_W  = SLOT_W + PAGE_W;
    localparam int PTE_W   = FRAME_W + 1;
    localparam int NUM_W   = 17;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    // Actions
    localparam logic [1:0] ACT_CREATE = 2'd0;
    localparam logic [1:0] ACT_LOAD   = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    // Result status codes
    localparam logic [3:0] ST_CREATED   = 4'd0;
    localparam logic [3:0] ST_LOADED    = 4'd1;
    localparam logic [3:0] ST_PRESENT   = 4'd2;
    localparam logic [3:0] ST_REMOVED   = 4'd3;
    localparam logic [3:0] ST_FULL      = 4'd4;
    localparam logic [3:0] ST_RANGE     = 4'd5;
    localparam logic [3:0] ST_NOFRAME   = 4'd6;
    localparam logic [3:0] ST_NOTLOADED = 4'd7;
    localparam logic [3:0] ST_NOTFOUND  = 4'd8;
    localparam logic [3:0] ST_TOOMANY   = 4'd9;

    // Configuration register indexes
    localparam logic CFG_PAGE_SIZE = 1'b0;
    localparam logic CFG_FRAMES    = 1'b1;

    typedef struct packed {
        logic       load_in;
        logic       clr_idx;
        logic       inc_idx;
        logic       set_slot;
        logic       div_start;
        logic       mem_rd;
        logic       wr_clear;
        logic       wr_load;
        logic       wr_remove;
        logic       slot_wr;
        logic       out_load;
        logic [3:0] code;
    } t_cmd;

    typedef struct packed {
        logic table_full;
        logic div_done;
        logic too_many;
        logic at_count;
        logic id_match;
        logic page_oor;
        logic clr_last;
        logic present;
        logic frame_hit;
        logic scan_end;
    } t_sts;

endpackage

/* rtl/core/ptfa_div.sv */
// Restoring divider, one quotient bit per cycle, for the page count
module ptfa_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ptfa_pkg::NUM_W-1:0] i_num,
    input  logic [15:0]                i_den,
    output logic                       o_done,
    output logic [ptfa_pkg::NUM_W-1:0] o_quo
);
    import ptfa_pkg::*;

    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [4:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [NUM_W-1:0] w_trial;
    logic             w_fit;

    // Shift in the next dividend bit and test against the divisor
    assign w_trial = {r_rem[NUM_W-2:0], r_quo[NUM_W-1]};
    assign w_fit   = w_trial >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 5'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= w_fit ? (w_trial - {1'b0, i_den}) : w_trial;
            r_quo <= {r_quo[NUM_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* rtl/core/ptfa_dp.sv */
// Datapath: tables, page entry memory, free map, counters and result register
module ptfa_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [ptfa_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_index,
    input  logic [15:0]                     i_cfg_data,
    input  logic                            i_m_tready,
    input  ptfa_pkg::t_cmd                  i_cmd,
    output ptfa_pkg::t_sts                  o_sts,
    output logic                            o_m_tvalid,
    output logic [ptfa_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import ptfa_pkg::*;

    logic [15:0]       r_pid;
    logic [15:0]       r_size;
    logic [7:0]        r_page;
    logic [IDX_W-1:0]  r_idx;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_count;
    logic [15:0]       r_page_size;
    logic [6:0]        r_frames;
    logic [NUM_FRAMES-1:0] r_free;
    logic [15:0]       r_slot_id  [MAX_PROCESSES];
    logic [PCNT_W-1:0] r_slot_pg  [MAX_PROCESSES];
    logic [PTE_W-1:0]  r_pte      [MAX_PROCESSES*MAX_PAGES];
    logic [PTE_W-1:0]  r_rd;
    logic              r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [15:0]        w_ps;
    logic [NUM_W-1:0]   w_num;
    logic               w_div_done;
    logic [NUM_W-1:0]   w_quo;
    logic [6:0]         w_limit;
    logic [ADDR_W-1:0]  w_addr;
    logic [PTE_W-1:0]   w_wdata;
    logic               w_wr;
    logic [FRAME_W-1:0] w_frame;
    logic [PCNT_W-1:0]  w_pages;

    // Page count divider: ceil(size / page_size), zero page size as one
    assign w_ps  = (r_page_size == 16'd0) ? 16'd1 : r_page_size;
    assign w_num = {1'b0, r_size} + {1'b0, w_ps} - 17'd1;

    ptfa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_ps),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size <= 16'd4;
            r_frames    <= 7'd64;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_PAGE_SIZE) begin
                r_page_size <= i_cfg_data;
            end else begin
                r_frames <= i_cfg_data[6:0];
            end
        end
    end

    // Capture the request item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_pid  <= i_s_tdata[15:0];
            r_size <= i_s_tdata[31:16];
            r_page <= i_s_tdata[39:32];
        end
    end

    // Walk index and selected slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_slot <= '0;
        end else begin
            if (i_cmd.clr_idx) begin
                r_idx <= '0;
            end else if (i_cmd.inc_idx) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.load_in) begin
                r_slot <= r_count[SLOT_W-1:0];
            end else if (i_cmd.set_slot) begin
                r_slot <= r_idx[SLOT_W-1:0];
            end
        end
    end

    // Process table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.slot_wr) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.slot_wr) begin
            r_slot_id[r_slot] <= r_pid;
            r_slot_pg[r_slot] <= w_quo[PCNT_W-1:0];
        end
    end

    // Page entry memory, one port, registered read
    assign w_addr  = i_cmd.wr_clear ? {r_slot, r_idx[PAGE_W-1:0]}
                                    : {r_slot, r_page[PAGE_W-1:0]};
    assign w_wdata = i_cmd.wr_load ? {1'b1, r_idx[FRAME_W-1:0]} : '0;
    assign w_wr    = i_cmd.wr_clear | i_cmd.wr_load | i_cmd.wr_remove;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_pte[w_addr] <= w_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rd <= r_pte[w_addr];
        end
    end

    // Free frame map: claim on load, release on remove
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
        end else begin
            if (i_cmd.wr_load) begin
                r_free[r_idx[FRAME_W-1:0]] <= 1'b0;
            end
            if (i_cmd.wr_remove) begin
                r_free[r_rd[FRAME_W-1:0]] <= 1'b1;
            end
        end
    end

    // Status toward the controller
    assign w_limit = (r_frames > 7'(NUM_FRAMES)) ? 7'(NUM_FRAMES) : r_frames;

    assign o_sts.table_full = r_count >= CNT_W'(MAX_PROCESSES);
    assign o_sts.div_done   = w_div_done;
    assign o_sts.too_many   = w_quo > NUM_W'(MAX_PAGES);
    assign o_sts.at_count   = r_idx == {2'b00, r_count};
    assign o_sts.id_match   = r_slot_id[r_idx[SLOT_W-1:0]] == r_pid;
    assign o_sts.page_oor   = r_page >= {1'b0, r_slot_pg[r_idx[SLOT_W-1:0]]};
    assign o_sts.clr_last   = r_idx[PAGE_W-1:0] == PAGE_W'(MAX_PAGES - 1);
    assign o_sts.present    = r_rd[PTE_W-1];
    assign o_sts.frame_hit  = r_free[r_idx[FRAME_W-1:0]];
    assign o_sts.scan_end   = r_idx >= w_limit;

    // Result fields by status
    assign w_frame = (i_cmd.code == ST_LOADED)  ? r_idx[FRAME_W-1:0] :
                     (i_cmd.code == ST_PRESENT) ? r_rd[FRAME_W-1:0]  : '0;
    assign w_pages = (i_cmd.code == ST_CREATED) ? w_quo[PCNT_W-1:0] : '0;

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {7'd0, w_pages, w_frame, i_cmd.code};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

/* rtl/core/ptfa_ctrl.sv */
// Controller state machine sequencing create, load and remove
module ptfa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic [1:0]     i_s_tuser,
    input  logic           i_m_tready,
    input  logic           i_out_valid,
    input  ptfa_pkg::t_sts i_sts,
    output ptfa_pkg::t_cmd o_cmd,
    output logic           o_s_tready
);
    import ptfa_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_DIVW = 4'd2;
    localparam logic [3:0] S_CLR  = 4'd3;
    localparam logic [3:0] S_SRCH = 4'd4;
    localparam logic [3:0] S_RD   = 4'd5;
    localparam logic [3:0] S_RDW  = 4'd6;
    localparam logic [3:0] S_SCAN = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0] r_state, n_state;
    logic [1:0] r_act, n_act;
    logic [3:0] r_code, n_code;
    logic       w_accept;
    logic       w_out_busy;

    assign o_s_tready = r_state == S_IDLE;
    assign w_accept   = i_s_tvalid & o_s_tready;
    assign w_out_busy = i_out_valid & ~i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act   <= ACT_NONE;
            r_code  <= ST_CREATED;
        end else begin
            r_state <= n_state;
            r_act   <= n_act;
            r_code  <= n_code;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_act   = r_act;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.code = r_code;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_in = 1'b1;
                    o_cmd.clr_idx = 1'b1;
                    n_act = i_s_tuser;
                    priority if (i_s_tuser == ACT_NONE) begin
                        n_state = S_IDLE;
                    end else if (i_s_tuser == ACT_CREATE) begin
                        if (i_sts.table_full) begin
                            n_code  = ST_FULL;
                            n_state = S_OUT;
                        end else begin
                            n_state = S_DIV;
                        end
                    end else begin
                        n_state = S_SRCH;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (i_sts.div_done) begin
                    if (i_sts.too_many) begin
                        n_code  = ST_TOOMANY;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_CLR;
                    end
                end
            end
            // Clear every page entry of the new slot
            S_CLR: begin
                o_cmd.wr_clear = 1'b1;
                o_cmd.inc_idx  = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.slot_wr = 1'b1;
                    n_code  = ST_CREATED;
                    n_state = S_OUT;
                end
            end
            // Find the first slot with the identifier
            S_SRCH: begin
                priority if (i_sts.at_count) begin
                    n_code  = ST_NOTFOUND;
                    n_state = S_OUT;
                end else if (i_sts.id_match) begin
                    o_cmd.set_slot = 1'b1;
                    if (i_sts.page_oor) begin
                        n_code  = ST_RANGE;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_RD;
                    end
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            S_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state = S_RDW;
            end
            S_RDW: begin
                if (r_act == ACT_LOAD) begin
                    if (i_sts.present) begin
                        n_code  = ST_PRESENT;
                        n_state = S_OUT;
                    end else begin
                        o_cmd.clr_idx = 1'b1;
                        n_state = S_SCAN;
                    end
                end else begin
                    if (i_sts.present) begin
                        o_cmd.wr_remove = 1'b1;
                        n_code  = ST_REMOVED;
                    end else begin
                        n_code  = ST_NOTLOADED;
                    end
                    n_state = S_OUT;
                end
            end
            // Scan frames from the lowest for a free one
            S_SCAN: begin
                priority if (i_sts.scan_end) begin
                    n_code  = ST_NOFRAME;
                    n_state = S_OUT;
                end else if (i_sts.frame_hit) begin
                    o_cmd.wr_load = 1'b1;
                    n_code  = ST_LOADED;
                    n_state = S_OUT;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            // Hand the result to the output register once it is free
            S_OUT: begin
                if (!w_out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/page_table_frame_allocator_core.sv */
// Paged memory allocator: process table, page tables and first free frame placement
// Usage: one request item enters on the slave stream (tuser = action: create, load,
// remove; tdata = process id, size, page number) and gives one result item on the
// master stream (status, frame index, page count); action 3 gives no result.
// Configuration writes (page size, frames in use) go on the cfg channel, always
// ready; the user must make them while the block is idle, which it does not enforce.
// Create starts the 17-bit divide for the page count, waits for it, sweeps the
// new page table clear and loads the result; a full table goes straight to the
// result. Load and remove search the process table one slot a cycle and read the
// page entry, and load then scans for a free frame one frame a cycle. One request
// is in work at a time.
// Reset: no processes, every frame free, page size 4, frames in use 64.
// A stalled receiver holds the result in the output register; a new request
// is still taken and finished, and waits before its result is loaded.
module page_table_frame_allocator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] process_id, [31:16] process_size, [39:32] page_number
    input  logic [ptfa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [3:0] status, [9:4] frame_index, [16:10] page_count, [23:17] zero
    output logic [ptfa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_index,
    input  logic [15:0]                     i_cfg_data
);
    import ptfa_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    ptfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tready  (m_axis_tready),
        .i_out_valid (m_axis_tvalid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_s_tready  (s_axis_tready)
    );

    ptfa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (m_axis_tready),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

/* rtl/core/ptfa_chk.sv */
// Port-level checker of the frame allocator core and its bind
`include "page_table_frame_allocator_core_defines.svh"

module ptfa_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [ptfa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [1:0]                      s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ptfa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic                            i_cfg_index,
    input logic [15:0]                     i_cfg_data
);
    import ptfa_pkg::*;

    // Stalled result holds
    `PTFA_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // Status is a defined code
    `PTFA_ASSERT_NOW(a_code, m_axis_tvalid, m_axis_tdata[3:0] <= ST_TOOMANY)
    // Frame index only on loaded or already present
    `PTFA_ASSERT_NOW(a_frame, m_axis_tvalid && m_axis_tdata[3:0] != ST_LOADED && m_axis_tdata[3:0] != ST_PRESENT, m_axis_tdata[9:4] == 6'd0)
    // Page count only on created, and within the page limit
    `PTFA_ASSERT_NOW(a_pages, m_axis_tvalid && m_axis_tdata[3:0] != ST_CREATED, m_axis_tdata[16:10] == 7'd0)
    `PTFA_ASSERT_NOW(a_limit, m_axis_tvalid, m_axis_tdata[16:10] <= 7'(MAX_PAGES) && m_axis_tdata[23:17] == 7'd0)

endmodule

bind page_table_frame_allocator_core ptfa_chk u_chk (.*);

/* bench/page_table_frame_allocator_checker.sv */
// Checker for the frame allocator core: predicts every result item and compares it
`timescale 1ns / 1ps

module page_table_frame_allocator_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_ready,
    input  logic [ptfa_pkg::IN_DATA_W-1:0]  i_req_data,
    input  logic [1:0]                      i_req_action,
    input  logic                            i_rsp_valid,
    input  logic                            i_rsp_ready,
    input  logic [ptfa_pkg::OUT_DATA_W-1:0] i_rsp_data,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic                            i_cfg_index,
    input  logic [15:0]                     i_cfg_data,
    output int                              o_pending,
    output int                              o_errors
);
    import ptfa_pkg::*;

    typedef struct packed {
        logic [3:0] status;
        logic [5:0] frame;
        logic [6:0] pages;
    } t_alloc_result;

    // Shadow copy of the allocator state and its registers
    logic [15:0] page_size;
    logic [6:0]  frames_in_use;
    int          proc_count;
    logic [15:0] slot_pid [MAX_PROCESSES];
    int          slot_npages [MAX_PROCESSES];
    logic        pte_present [MAX_PROCESSES][MAX_PAGES];
    logic [5:0]  pte_frame [MAX_PROCESSES][MAX_PAGES];
    logic        frame_is_free [NUM_FRAMES];

    t_alloc_result results_due[$];

    // Apply one request to the shadow state and return its result
    function automatic t_alloc_result allocate_request(logic [1:0] act, logic [15:0] pid,
                                                       logic [15:0] psize, logic [7:0] page);
        t_alloc_result r;
        int slot;
        int divisor;
        int npages;
        int limit;
        r = '0;
        if (act == ACT_CREATE) begin
            if (proc_count >= MAX_PROCESSES) begin
                r.status = ST_FULL;
                return r;
            end
            divisor = (page_size == 0) ? 1 : int'(page_size);
            npages = (int'(psize) + divisor - 1) / divisor;
            if (npages > MAX_PAGES) begin
                r.status = ST_TOOMANY;
                return r;
            end
            slot_pid[proc_count] = pid;
            slot_npages[proc_count] = npages;
            for (int p = 0; p < MAX_PAGES; p++) begin
                pte_present[proc_count][p] = 1'b0;
                pte_frame[proc_count][p] = '0;
            end
            proc_count++;
            r.status = ST_CREATED;
            r.pages = npages[6:0];
            return r;
        end
        slot = -1;
        for (int s = 0; s < proc_count; s++) begin
            if (slot < 0 && slot_pid[s] == pid) slot = s;
        end
        if (slot < 0) begin
            r.status = ST_NOTFOUND;
            return r;
        end
        if (int'(page) >= slot_npages[slot]) begin
            r.status = ST_RANGE;
            return r;
        end
        if (act == ACT_LOAD) begin
            if (pte_present[slot][page]) begin
                r.status = ST_PRESENT;
                r.frame = pte_frame[slot][page];
                return r;
            end
            limit = (frames_in_use < NUM_FRAMES) ? int'(frames_in_use) : NUM_FRAMES;
            r.status = ST_NOFRAME;
            for (int f = 0; f < limit; f++) begin
                if (r.status == ST_NOFRAME && frame_is_free[f]) begin
                    frame_is_free[f] = 1'b0;
                    pte_present[slot][page] = 1'b1;
                    pte_frame[slot][page] = f[5:0];
                    r.status = ST_LOADED;
                    r.frame = f[5:0];
                end
            end
            return r;
        end
        // Remove: free the frame even if it lies beyond frames in use
        if (!pte_present[slot][page]) begin
            r.status = ST_NOTLOADED;
            return r;
        end
        frame_is_free[pte_frame[slot][page]] = 1'b1;
        pte_present[slot][page] = 1'b0;
        pte_frame[slot][page] = '0;
        r.status = ST_REMOVED;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_alloc_result seen;
        t_alloc_result want;
        if (!i_rst_n) begin
            page_size = 16'd4;
            frames_in_use = 7'd64;
            proc_count = 0;
            for (int f = 0; f < NUM_FRAMES; f++) frame_is_free[f] = 1'b1;
            results_due.delete();
            o_pending = 0;
            o_errors = 0;
        end else begin
            // Track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_PAGE_SIZE) page_size = i_cfg_data;
                else frames_in_use = i_cfg_data[6:0];
            end
            // Predict each accepted request item; the idle action gives nothing
            if (i_req_valid && i_req_ready && i_req_action != ACT_NONE) begin
                results_due.push_back(allocate_request(i_req_action, i_req_data[15:0],
                                                       i_req_data[31:16],
                                                       i_req_data[39:32]));
            end
            // Compare each accepted result item with the oldest prediction
            if (i_rsp_valid && i_rsp_ready) begin
                seen.status = i_rsp_data[3:0];
                seen.frame = i_rsp_data[9:4];
                seen.pages = i_rsp_data[16:10];
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result status=%0d frame=%0d pages=%0d",
                             $time, seen.status, seen.frame, seen.pages);
                    o_errors++;
                end else begin
                    want = results_due.pop_front();
                    if (seen.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, seen.status);
                        o_errors++;
                    end
                    if (seen.frame !== want.frame) begin
                        $display("%0t: frame_index expected %0d actual %0d",
                                 $time, want.frame, seen.frame);
                        o_errors++;
                    end
                    if (seen.pages !== want.pages) begin
                        $display("%0t: page_count expected %0d actual %0d",
                                 $time, want.pages, seen.pages);
                        o_errors++;
                    end
                end
            end
            o_pending = results_due.size();
        end
    end

endmodule

/* bench/testbench.sv */
// Top of the frame allocator bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
    import ptfa_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 100;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic                  i_cfg_index;
    logic [15:0]           i_cfg_data;
    int                    pending;
    int                    errors;
    int                    cycles;
    logic                  no_idle;
    logic                  long_hold;
    logic [15:0]           known_pids[$];

    page_table_frame_allocator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    page_table_frame_allocator_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata), .i_req_action(s_axis_tuser),
        .i_rsp_valid(m_axis_tvalid), .i_rsp_ready(m_axis_tready),
        .i_rsp_data(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_pending(pending), .o_errors(errors)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // End the run at the cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL page_table_frame_allocator_core");
            $finish;
        end
    end

    // Stall the result side in random bursts, with one long hold-off on request
    initial begin
        int n;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
                long_hold = 1'b0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(1, 7);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one request item and hold it until accepted
    task automatic send_request(logic [1:0] act, logic [15:0] pid, logic [15:0] psize,
                                logic [7:0] page);
        int n;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            n = $urandom_range(1, 7);
            repeat (n) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {page, psize, pid};
        if (act == ACT_CREATE) known_pids.push_back(pid);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write both registers once the block has gone idle
    task automatic write_config(logic [15:0] psize_reg, logic [6:0] frames_reg);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        for (int k = 0; k < 2; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= (k == 0) ? CFG_PAGE_SIZE : CFG_FRAMES;
            i_cfg_data <= (k == 0) ? psize_reg : {9'd0, frames_reg};
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly load and remove on live processes, some creates and noise
    task automatic send_random_request();
        int r;
        logic [15:0] pid;
        logic [15:0] psize;
        logic [7:0] page;
        r = $urandom_range(0, 99);
        if (known_pids.size() > 0 && $urandom_range(0, 9) != 0)
            pid = known_pids[$urandom_range(0, known_pids.size() - 1)];
        else
            pid = 16'($urandom_range(0, 65535));
        page = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 15));
        psize = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 80));
        if (r < 6) send_request(ACT_CREATE, pid, psize, page);
        else if (r < 9) send_request(ACT_NONE, 16'($urandom_range(0, 65535)),
                                     16'($urandom_range(0, 65535)), page);
        else if (r < 60) send_request(ACT_LOAD, pid, 16'($urandom_range(0, 65535)), page);
        else send_request(ACT_REMOVE, pid, 16'($urandom_range(0, 65535)), page);
    endtask

    initial begin
        int limit;
        cycles = 0;
        no_idle = 1'b0;
        long_hold = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ACT_CREATE;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_PAGE_SIZE;
        i_cfg_data = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: field extremes, every status but table full and no frame, duplicate ids, idle action
        send_request(ACT_CREATE, 16'd0, 16'd0, 8'd0);
        send_request(ACT_CREATE, 16'hFFFF, 16'd256, 8'd0);
        send_request(ACT_CREATE, 16'd1, 16'd257, 8'd0);
        send_request(ACT_CREATE, 16'hFFFF, 16'd8, 8'd0);
        send_request(ACT_LOAD, 16'd0, 16'hFFFF, 8'd0);
        send_request(ACT_LOAD, 16'hFFFF, 16'd0, 8'd63);
        send_request(ACT_LOAD, 16'hFFFF, 16'd0, 8'd63);
        send_request(ACT_LOAD, 16'hFFFF, 16'd0, 8'd64);
        send_request(ACT_LOAD, 16'hFFFF, 16'd0, 8'd255);
        send_request(ACT_LOAD, 16'd1234, 16'd0, 8'd0);
        send_request(ACT_LOAD, 16'hFFFF, 16'd0, 8'd1);
        send_request(ACT_REMOVE, 16'hFFFF, 16'd0, 8'd63);
        send_request(ACT_REMOVE, 16'hFFFF, 16'd0, 8'd63);
        send_request(ACT_REMOVE, 16'd9, 16'd0, 8'd0);
        send_request(ACT_NONE, 16'hFFFF, 16'hFFFF, 8'hFF);

        // Zero page size counts as one; a single frame runs out at once
        write_config(16'd0, 7'd1);
        send_request(ACT_CREATE, 16'd2, 16'hFFFF, 8'd0);
        send_request(ACT_CREATE, 16'd2, 16'd3, 8'd0);
        send_request(ACT_LOAD, 16'd2, 16'd0, 8'd0);
        send_request(ACT_LOAD, 16'd2, 16'd0, 8'd1);
        send_request(ACT_REMOVE, 16'hFFFF, 16'd0, 8'd1);

        // Largest page size; frames in use above the frame count
        write_config(16'hFFFF, 7'd127);
        send_request(ACT_CREATE, 16'd3, 16'hFFFF, 8'd0);
        send_request(ACT_LOAD, 16'd3, 16'd0, 8'd0);
        send_request(ACT_LOAD, 16'd2, 16'd0, 8'd1);

        // Random phases under varied settings
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_config(16'd1, 7'd64);
                1: write_config(16'($urandom_range(1, 8)), 7'($urandom_range(1, 20)));
                2: write_config(16'd2, 7'd0);
                default: write_config(16'($urandom_range(1, 65535)), 7'd64);
            endcase
            if (ph == 1) long_hold = 1'b1;
            limit = 95;
            for (int k = 0; k < limit; k++) begin
                if (ph == 3 && k == 50) no_idle = 1'b1;
                send_random_request();
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0) begin
            $display("PASS page_table_frame_allocator_core");
        end else begin
            $display("FAIL page_table_frame_allocator_core");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ptfa_pkg.sv
rtl/core/ptfa_div.sv
rtl/core/ptfa_dp.sv
rtl/core/ptfa_ctrl.sv
rtl/core/page_table_frame_allocator_core.sv
rtl/core/ptfa_chk.sv
bench/page_table_frame_allocator_checker.sv
bench/testbench.sv
